/* src/dmsd_pkg.sv */
// shared widths, reset values, register indexes and phase codes of the double marker deframer
package dmsd_pkg;

    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = 12;
    localparam int TDATA_OUT_W = 16;
    localparam int TUSER_OUT_W = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'd85;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_MARKER   = 2'd1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_TAIL   = 4'b1000
    } t_phase;

endpackage

/* src/double_marker_sample_deframer_unit.sv */
// top level of the double marker deframer: byte stream in, samples and frame ends out
//
// s_axis carries one received byte per beat in tdata[7:0]. A frame opens with two
// header marker bytes in a row and closes with two tail marker bytes in a row; a
// lone tail byte followed by another byte makes both of them body data. Body bytes
// pair little-endian and each word leaves as a 12-bit sample on m_axis as soon as
// it is confirmed. The closing beat has tlast set and tuser[1] tells whether an
// unpaired body byte was dropped. Bytes outside a frame give no beat.
// The cfg channel writes header_marker (index 0) or tail_marker (index 1); it is
// always ready and a write acts on the next byte.
// The result beat of an accepted byte is registered and appears in the next cycle, and one
// byte is taken every cycle while m_axis does not stall; the output register is the only stage.
// While m_axis stalls with a beat held, s_axis_tready drops and the byte waits.
// Reset restores the marker values 170 and 85, returns to idle outside any frame
// and empties the output register.
module double_marker_sample_deframer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dmsd_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dmsd_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,   // [11:0] sample, [15:12] zero
    output logic [dmsd_pkg::TUSER_OUT_W-1:0]    m_axis_tuser,   // [0] sample_valid, [1] odd_byte_dropped
    output logic                                m_axis_tlast,   // frame_end
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dmsd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dmsd_pkg::BYTE_W-1:0]         i_cfg_data
);
    import dmsd_pkg::*;

    logic [BYTE_W-1:0]   r_header;
    logic [BYTE_W-1:0]   r_tail;
    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_held, n_held;
    logic                r_held_ok, n_held_ok;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic                r_out_sv;
    logic                r_out_last;
    logic                r_out_odd;

    logic                in_beat;
    logic                res_valid;
    logic [SAMPLE_W-1:0] res_sample;
    logic                res_sv;
    logic                res_last;
    logic                res_odd;
    logic [BYTE_W-1:0]   c;
    logic [2*BYTE_W-1:0] word;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign c             = s_axis_tdata;

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_held_ok  = r_held_ok;
        res_valid  = 1'b0;
        res_sv     = 1'b0;
        res_last   = 1'b0;
        res_odd    = 1'b0;
        word       = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (c == r_header) n_phase = PH_HEADER;
            end
            PH_HEADER: begin
                if (c == r_header) begin
                    n_phase   = PH_BODY;
                    n_held_ok = 1'b0;
                    n_held    = '0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_BODY: begin
                if (c == r_tail) begin
                    n_phase = PH_TAIL;
                end else if (r_held_ok) begin
                    word      = {c, r_held};
                    res_valid = 1'b1;
                    res_sv    = 1'b1;
                    n_held_ok = 1'b0;
                    n_held    = '0;
                end else begin
                    n_held    = c;
                    n_held_ok = 1'b1;
                end
            end
            PH_TAIL: begin
                if (c == r_tail) begin
                    n_phase   = PH_IDLE;
                    res_valid = 1'b1;
                    res_last  = 1'b1;
                    res_odd   = r_held_ok;
                    n_held_ok = 1'b0;
                    n_held    = '0;
                end else begin
                    // pending tail byte and this byte are both data
                    n_phase   = PH_BODY;
                    res_valid = 1'b1;
                    res_sv    = 1'b1;
                    if (r_held_ok) begin
                        word      = {r_tail, r_held};
                        n_held    = c;
                        n_held_ok = 1'b1;
                    end else begin
                        word      = {c, r_tail};
                        n_held    = '0;
                        n_held_ok = 1'b0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        res_sample = word[SAMPLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_tail   <= TAIL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_HEADER_MARKER) r_header <= i_cfg_data;
            if (i_cfg_index == REG_TAIL_MARKER)   r_tail   <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_held_ok <= 1'b0;
            r_held    <= '0;
        end else if (in_beat) begin
            r_phase   <= n_phase;
            r_held_ok <= n_held_ok;
            r_held    <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= in_beat && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && res_valid) begin
            r_out_sample <= res_sample;
            r_out_sv     <= res_sv;
            r_out_last   <= res_last;
            r_out_odd    <= res_odd;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_OUT_W-SAMPLE_W){1'b0}}, r_out_sample};
    assign m_axis_tuser  = {r_out_odd, r_out_sv};
    assign m_axis_tlast  = r_out_last;

    // frame end beat carries no sample
    a_end_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tuser[0] && m_axis_tdata == '0))
        else $error("frame end beat carries a sample");

    // sample beat carries no frame end flags
    a_sample_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[0] && !m_axis_tuser[1]))
        else $error("sample beat has wrong flags");

    // a data byte after a lone tail byte always completes a word
    a_tail_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && r_phase == PH_TAIL && c != r_tail) |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("lone tail byte did not yield a sample");

    // a low byte is only held inside a body
    a_held_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_ok |-> (r_phase == PH_BODY || r_phase == PH_TAIL))
        else $error("low byte held outside a body");

endmodule
